/* sv/wfhs_pkg.sv */
// Shared types and constants for the waypoint frame/heading/speed block.
// No dependencies.
package wfhs_pkg;

  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 48;

  localparam logic [CfgIdxW-1:0] RegRotXx = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRotXy = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRotYx = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRotYy = 3'd3;
  localparam logic [CfgIdxW-1:0] RegShiftX = 3'd4;
  localparam logic [CfgIdxW-1:0] RegShiftY = 3'd5;

  localparam logic signed [31:0] RotOne = 32'sd1073741824;
  localparam logic signed [63:0] HalfPiQ28 = 64'sd421657428;
  localparam logic signed [63:0] GainInvQ30 = 64'sd652032874;
  localparam logic signed [63:0] PosMax = 64'sd140737488355327;
  localparam logic signed [63:0] PosMin = -64'sd140737488355328;
  localparam logic signed [17:0] YawHi = 18'sd25735;
  localparam logic signed [17:0] YawLo = -18'sd25736;
  localparam logic signed [17:0] TwoPiQ13 = 18'sd51472;

  typedef struct packed {
    logic signed [47:0] ego_x;
    logic signed [47:0] ego_y;
    logic signed [23:0] dir_cos;
    logic signed [23:0] dir_sin;
    logic               start_flag;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] map_x;
    logic signed [47:0] map_y;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic        [47:0] speed;
  } out_item_t;

  typedef struct packed {
    logic signed [47:0] map_x;
    logic signed [47:0] map_y;
    logic signed [63:0] vx;
    logic signed [63:0] vy;
    logic               start_flag;
  } job_t;

  typedef enum logic [2:0] {
    StIdle, StVec, StRot, StSum, StSqrt, StOut
  } back_state_e;

  function automatic logic signed [63:0] atan_step(input logic [5:0] i);
    logic signed [63:0] r;
    case (i)
      6'd0: r = 64'sd210828714;
      6'd1: r = 64'sd124459457;
      6'd2: r = 64'sd65760959;
      6'd3: r = 64'sd33381290;
      6'd4: r = 64'sd16755422;
      6'd5: r = 64'sd8385879;
      6'd6: r = 64'sd4193963;
      6'd7: r = 64'sd2097109;
      6'd8: r = 64'sd1048571;
      6'd9: r = 64'sd524287;
      default: r = (i <= 6'd28) ? (64'sd1 <<< (6'd28 - i)) : 64'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] to_q14(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + 64'sd32768) >>> 16;
    if (r > 64'sd16384) r = 64'sd16384;
    if (r < -64'sd16384) r = -64'sd16384;
    return r[15:0];
  endfunction

endpackage

/* sv/wfhs_stream_if.sv */
// Valid/ready channel carrying one payload item.
// Depends on nothing; payload type is a parameter.
interface wfhs_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/waypoint_frame_heading_speed.sv */
// Top level: config registers, front end, queue, back end.
// Uses wfhs_pkg, wfhs_stream_if, wfhs_front, wfhs_queue, wfhs_back.
//
//  channel  | dir | payload
//  in_if    | in  | ego_x, ego_y, dir_cos, dir_sin, start_flag
//  out_if   | out | map_x, map_y, yaw_angle, quat_z, quat_w, speed
//  cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i
//
// In the back end an item passes through these steps: taking the job, the two CORDIC
// passes, building the sum of squares, finding the root one bit at a time, and
// loading the output register. The front end maps positions in its partial-product and
// job register stages and the queue holds two more items. Reset is asynchronous, active low.
// Output is a register and stalls independently of input.
module waypoint_frame_heading_speed #(
  parameter int unsigned CordicSteps = wfhs_pkg::CordicStepsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wfhs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wfhs_pkg::CfgDataW-1:0] cfg_data_i,
  wfhs_stream_if.sink                   in_if,
  wfhs_stream_if.source                 out_if
);
  logic signed [31:0] rxx_q, rxy_q, ryx_q, ryy_q;
  logic signed [47:0] shx_q, shy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rxx_q <= wfhs_pkg::RotOne;
      rxy_q <= '0;
      ryx_q <= '0;
      ryy_q <= wfhs_pkg::RotOne;
      shx_q <= '0;
      shy_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wfhs_pkg::RegRotXx:  rxx_q <= cfg_data_i[31:0];
        wfhs_pkg::RegRotXy:  rxy_q <= cfg_data_i[31:0];
        wfhs_pkg::RegRotYx:  ryx_q <= cfg_data_i[31:0];
        wfhs_pkg::RegRotYy:  ryy_q <= cfg_data_i[31:0];
        wfhs_pkg::RegShiftX: shx_q <= cfg_data_i;
        wfhs_pkg::RegShiftY: shy_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic jv, jr, qv, qr;
  wfhs_pkg::job_t jd, qd;

  wfhs_front u_front (
    .clk_i, .rst_ni,
    .rot_xx_i(rxx_q), .rot_xy_i(rxy_q), .rot_yx_i(ryx_q), .rot_yy_i(ryy_q),
    .shift_x_i(shx_q), .shift_y_i(shy_q),
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .in_data_i(in_if.data),
    .job_valid_o(jv), .job_ready_i(jr), .job_o(jd)
  );

  wfhs_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(jv), .wr_ready_o(jr), .wr_data_i(jd),
    .rd_valid_o(qv), .rd_ready_i(qr), .rd_data_o(qd)
  );

  wfhs_back #(.CordicSteps(CordicSteps)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i(qv), .job_ready_o(qr), .job_i(qd),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .out_o(out_if.data)
  );
endmodule

/* sv/wfhs_front.sv */
// Front end: maps the waypoint to the map frame and rotates the heading vector.
// Uses wfhs_pkg; two register stages, multiplies split over 24-bit halves.
module wfhs_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [31:0]                rot_xx_i,
  input  logic signed [31:0]                rot_xy_i,
  input  logic signed [31:0]                rot_yx_i,
  input  logic signed [31:0]                rot_yy_i,
  input  logic signed [47:0]                shift_x_i,
  input  logic signed [47:0]                shift_y_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  wfhs_pkg::in_item_t                in_data_i,
  output logic                              job_valid_o,
  input  logic                              job_ready_i,
  output wfhs_pkg::job_t                    job_o
);
  // stage 1: partial products
  logic s1_q;
  logic signed [63:0] ax_q, bx_q, ay_q, by_q, vx_q, vy_q;
  logic signed [47:0] shx_q, shy_q;
  logic st1_q;
  logic s2_q;
  wfhs_pkg::job_t job_q;
  logic adv2, adv1;

  logic signed [23:0] hx, hy;
  logic signed [24:0] lx, ly;
  assign hx = in_data_i.ego_x[47:24];
  assign hy = in_data_i.ego_y[47:24];
  assign lx = {1'b0, in_data_i.ego_x[23:0]};
  assign ly = {1'b0, in_data_i.ego_y[23:0]};

  assign adv2 = s1_q && (!s2_q || job_ready_i);
  assign adv1 = !s1_q || adv2;
  assign in_ready_o = adv1;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && adv1) begin
      ax_q <= 64'(rot_xx_i * hx) + 64'(rot_xy_i * hy);
      ay_q <= 64'(rot_yx_i * hx) + 64'(rot_yy_i * hy);
      bx_q <= 64'(rot_xx_i * lx) + 64'(rot_xy_i * ly) + (64'sd1 <<< 29);
      by_q <= 64'(rot_yx_i * lx) + 64'(rot_yy_i * ly) + (64'sd1 <<< 29);
      vx_q <= 64'(rot_xx_i * in_data_i.dir_cos) + 64'(rot_xy_i * in_data_i.dir_sin);
      vy_q <= 64'(rot_yx_i * in_data_i.dir_cos) + 64'(rot_yy_i * in_data_i.dir_sin);
      shx_q <= shift_x_i;
      shy_q <= shift_y_i;
      st1_q <= in_data_i.start_flag;
    end
  end

  function automatic logic signed [47:0] fin(input logic signed [63:0] a,
                                            input logic signed [63:0] b,
                                            input logic signed [47:0] sh);
    logic signed [63:0] c, m;
    c = (a + (b >>> 24)) >>> 6;
    m = c + 64'(sh);
    if (m > wfhs_pkg::PosMax) m = wfhs_pkg::PosMax;
    if (m < wfhs_pkg::PosMin) m = wfhs_pkg::PosMin;
    return m[47:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      job_q.map_x <= fin(ax_q, bx_q, shx_q);
      job_q.map_y <= fin(ay_q, by_q, shy_q);
      job_q.vx <= vx_q;
      job_q.vy <= vy_q;
      job_q.start_flag <= st1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
      s2_q <= 1'b0;
    end else begin
      if (adv1) s1_q <= in_valid_i;
      if (adv2) s2_q <= 1'b1;
      else if (job_ready_i) s2_q <= 1'b0;
    end
  end

  assign job_valid_o = s2_q;
  assign job_o = job_q;
endmodule

/* sv/wfhs_queue.sv */
// Two-entry queue between front and back ends.
// Uses wfhs_pkg job type.
module wfhs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  wfhs_pkg::job_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output wfhs_pkg::job_t rd_data_o
);
  wfhs_pkg::job_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;
  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

/* sv/wfhs_back.sv */
// Back end: CORDIC heading, CORDIC half-angle quaternion, bitwise square root.
// Uses wfhs_pkg; one shared CORDIC stepper and one 27x27 multiplier for all squares.
module wfhs_back #(
  parameter int unsigned CordicSteps = wfhs_pkg::CordicStepsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  output logic                 job_ready_o,
  input  wfhs_pkg::job_t       job_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output wfhs_pkg::out_item_t  out_o
);
  localparam int unsigned StepW = $clog2(CordicSteps + 1);

  wfhs_pkg::back_state_e st_q, st_d;
  logic signed [63:0] x_q, y_q, z_q;
  logic [5:0] i_q;
  logic [StepW-1:0] n_q;
  logic signed [47:0] mx_q, my_q, px_q, py_q;
  logic [51:0] adx_q, ady_q;
  logic [103:0] tot_q;
  logic [53:0] root_q;
  logic [1:0] ph_q;
  logic sel_q;
  logic [107:0] acc_q;
  logic signed [15:0] yaw_q;
  wfhs_pkg::out_item_t res_q;
  logic out_v_q;

  logic signed [63:0] dx, dy, at;
  logic [53:0] cand;
  logic [53:0] sq;
  logic [26:0] pa, pb;
  logic [107:0] pp;
  logic last;

  assign at = wfhs_pkg::atan_step(i_q);
  assign dx = y_q >>> i_q;
  assign dy = x_q >>> i_q;
  assign last = n_q == StepW'(CordicSteps - 1);

  // square in three 27x27 parts: distance terms first, then root candidates
  assign cand = root_q | (54'd1 << i_q);
  assign sq = (st_q == wfhs_pkg::StSum) ? (sel_q ? {2'b0, ady_q} : {2'b0, adx_q}) : cand;
  always_comb begin
    case (ph_q)
      2'd0: begin pa = sq[26:0];  pb = sq[26:0];  end
      2'd1: begin pa = sq[26:0];  pb = sq[53:27]; end
      2'd2: begin pa = sq[53:27]; pb = sq[53:27]; end
      default: begin pa = '0; pb = '0; end
    endcase
    pp = {54'd0, 54'(pa) * 54'(pb)};
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      wfhs_pkg::StIdle: if (job_valid_i) st_d = wfhs_pkg::StVec;
      wfhs_pkg::StVec:  if (last) st_d = wfhs_pkg::StRot;
      wfhs_pkg::StRot:  if (last) st_d = wfhs_pkg::StSum;
      wfhs_pkg::StSum:  if (ph_q == 2'd3 && sel_q) st_d = wfhs_pkg::StSqrt;
      wfhs_pkg::StSqrt: if (ph_q == 2'd3 && i_q == 6'd0) st_d = wfhs_pkg::StOut;
      wfhs_pkg::StOut:  if (!out_v_q || out_ready_i) st_d = wfhs_pkg::StIdle;
      default: st_d = wfhs_pkg::StIdle;
    endcase
  end

  always_comb begin
    job_ready_o = st_q == wfhs_pkg::StIdle;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0;
      py_q <= '0;
    end else begin
      case (st_q)
        wfhs_pkg::StIdle: begin
          mx_q <= job_i.map_x;
          my_q <= job_i.map_y;
          i_q <= '0;
          n_q <= '0;
          if (job_valid_i && job_i.start_flag) begin
            px_q <= '0;
            py_q <= '0;
          end
          // quadrant pre-rotation
          if (job_i.vx < 0 && job_i.vy >= 0) begin
            x_q <= job_i.vy; y_q <= -job_i.vx; z_q <= wfhs_pkg::HalfPiQ28;
          end else if (job_i.vx < 0) begin
            x_q <= -job_i.vy; y_q <= job_i.vx; z_q <= -wfhs_pkg::HalfPiQ28;
          end else begin
            x_q <= job_i.vx; y_q <= job_i.vy; z_q <= '0;
          end
          yaw_q <= (job_i.vx == 0 && job_i.vy == 0) ? 16'sd0 : 16'sd1;
        end
        wfhs_pkg::StVec: begin
          if (last) begin
            // zero vector marked by yaw_q==0 gives heading zero
            logic signed [63:0] zf;
            logic signed [17:0] yy;
            zf = ((y_q >= 0) ? z_q + at : z_q - at) + 64'sd16384;
            zf = zf >>> 15;
            yy = zf[17:0];
            if (yy > wfhs_pkg::YawHi) yy = yy - wfhs_pkg::TwoPiQ13;
            if (yy < wfhs_pkg::YawLo) yy = yy + wfhs_pkg::TwoPiQ13;
            if (yaw_q == 16'sd0) yy = '0;
            yaw_q <= yy[15:0];
            z_q <= 64'(yy) * 64'sd16384;
            x_q <= wfhs_pkg::GainInvQ30;
            y_q <= '0;
            i_q <= '0;
            n_q <= '0;
          end else begin
            if (y_q >= 0) begin
              x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + at;
            end else begin
              x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - at;
            end
            i_q <= i_q + 6'd1;
            n_q <= n_q + StepW'(1);
          end
        end
        wfhs_pkg::StRot: begin
          if (z_q >= 0) begin
            x_q <= x_q - dx; y_q <= y_q + dy;
          end else begin
            x_q <= x_q + dx; y_q <= y_q - dy;
          end
          if (last) begin
            logic signed [53:0] ex, ey;
            ex = (54'(mx_q) - 54'(px_q)) * 54'sd10;
            ey = (54'(my_q) - 54'(py_q)) * 54'sd10;
            adx_q <= ex[53] ? 52'(-ex) : ex[51:0];
            ady_q <= ey[53] ? 52'(-ey) : ey[51:0];
            i_q <= 6'd53;
            ph_q <= 2'd0;
            sel_q <= 1'b0;
            root_q <= '0;
            acc_q <= '0;
            tot_q <= '0;
            px_q <= mx_q;
            py_q <= my_q;
          end else begin
            z_q <= (z_q >= 0) ? z_q - at : z_q + at;
            i_q <= i_q + 6'd1;
            n_q <= n_q + StepW'(1);
          end
        end
        wfhs_pkg::StSum: begin
          // x term, then y term, each as three partial products and then an add into the total
          case (ph_q)
            2'd0: begin acc_q <= pp; ph_q <= 2'd1; end
            2'd1: begin acc_q <= acc_q + (pp << 28); ph_q <= 2'd2; end
            2'd2: begin acc_q <= acc_q + (pp << 54); ph_q <= 2'd3; end
            default: begin
              tot_q <= tot_q + acc_q[103:0];
              acc_q <= '0;
              ph_q <= 2'd0;
              sel_q <= 1'b1;
            end
          endcase
        end
        wfhs_pkg::StSqrt: begin
          case (ph_q)
            2'd0: begin acc_q <= pp; ph_q <= 2'd1; end
            2'd1: begin acc_q <= acc_q + (pp << 28); ph_q <= 2'd2; end
            2'd2: begin acc_q <= acc_q + (pp << 54); ph_q <= 2'd3; end
            default: begin
              if (acc_q <= 108'(tot_q)) root_q <= cand;
              acc_q <= '0;
              ph_q <= 2'd0;
              if (i_q != 6'd0) i_q <= i_q - 6'd1;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == wfhs_pkg::StOut && (!out_v_q || out_ready_i)) begin
      res_q.map_x <= mx_q;
      res_q.map_y <= my_q;
      res_q.yaw_angle <= yaw_q;
      res_q.quat_z <= wfhs_pkg::to_q14(y_q);
      res_q.quat_w <= wfhs_pkg::to_q14(x_q);
      res_q.speed <= (root_q[53:48] != '0) ? '1 : root_q[47:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= wfhs_pkg::StIdle;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == wfhs_pkg::StOut && (!out_v_q || out_ready_i)) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o = res_q;
endmodule
